@@ sv/rbsi_pkg.sv @@
// Shared types, constants and a helper function of the ray versus box slab tester.
package rbsi_pkg;

  // Fractional bits of every coordinate, bound and distance.
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  // A bound minus an origin needs 33 bits, and the scaled magnitude FRAC_BITS more.
  localparam int NUM_W     = COORD_W + 1 + FRAC_BITS;
  // One quotient bit is resolved per divider step.
  localparam int DIV_STEPS = COORD_W;
  localparam int NUM_AXES  = 3;

  // Pipeline stage positions.
  localparam int ST_PREP   = 0;
  localparam int ST_DIV    = 1;
  localparam int ST_ORDER  = ST_DIV + DIV_STEPS + 1;
  localparam int ST_MERGE  = ST_ORDER + 1;
  localparam int NSTG      = ST_MERGE + 1;

  localparam int MIND_W    = 17;
  localparam int ADDR_W    = 5;
  localparam int IDX_W     = 3;

  localparam logic signed [COORD_W-1:0] T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] T_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;
  localparam logic [IDX_W-1:0] REG_MIN_DIST  = 3'd6;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] distance;
  } res_t;

  // Applies the sign to an unsigned quotient magnitude and clamps it to 32 bits.
  function automatic logic signed [COORD_W-1:0] sat_quo(
    input logic [COORD_W-1:0] q,
    input logic               ovf,
    input logic               neg
  );
    logic signed [COORD_W-1:0] res;
    if (ovf) begin
      res = neg ? T_MIN : T_MAX;
    end else if (neg) begin
      res = (q > {1'b1, {(COORD_W-1){1'b0}}}) ? T_MIN : -$signed(q);
    end else begin
      res = q[COORD_W-1] ? T_MAX : $signed(q);
    end
    return res;
  endfunction

endpackage

@@ sv/rbsi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with early overflow detection.
module rbsi_div import rbsi_pkg::*; (
  input  logic                clk,
  input  logic [DIV_STEPS:0]  en,
  input  logic [NUM_W-1:0]    num_mag,
  input  logic [COORD_W-1:0]  den_mag,
  input  logic                neg,
  output logic [COORD_W-1:0]  quo,
  output logic                ovf,
  output logic                neg_o
);

  logic [COORD_W-1:0] rem_r [0:DIV_STEPS];
  logic [COORD_W-1:0] low_r [0:DIV_STEPS];
  logic [COORD_W-1:0] quo_r [0:DIV_STEPS];
  logic [COORD_W-1:0] den_r [0:DIV_STEPS];
  logic               neg_r [0:DIV_STEPS];
  logic               ovf_r [0:DIV_STEPS];
  logic [COORD_W-1:0] hi_part;

  // The quotient fits 32 bits exactly when the upper numerator part is below the divisor.
  assign hi_part = COORD_W'(num_mag[NUM_W-1:COORD_W]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= hi_part;
      low_r[0] <= num_mag[COORD_W-1:0];
      quo_r[0] <= '0;
      den_r[0] <= den_mag;
      neg_r[0] <= neg;
      ovf_r[0] <= (hi_part >= den_mag);
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [COORD_W:0] sh;
    logic             ge;
    logic [COORD_W:0] diff;

    assign sh   = {rem_r[k-1], low_r[k-1][COORD_W-1]};
    assign diff = sh - {1'b0, den_r[k-1]};
    assign ge   = (sh >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= ge ? diff[COORD_W-1:0] : sh[COORD_W-1:0];
        low_r[k] <= {low_r[k-1][COORD_W-2:0], 1'b0};
        quo_r[k] <= {quo_r[k-1][COORD_W-2:0], ge};
        den_r[k] <= den_r[k-1];
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quo   = quo_r[DIV_STEPS];
  assign ovf   = ovf_r[DIV_STEPS];
  assign neg_o = neg_r[DIV_STEPS];

endmodule

@@ sv/rbsi_slab.sv @@
// One axis lane: scales the bound offsets, divides both, and orders the slab interval.
module rbsi_slab import rbsi_pkg::*; (
  input  logic                      clk,
  input  logic [ST_ORDER:0]         en,
  input  logic signed [COORD_W-1:0] bound_lo,
  input  logic signed [COORD_W-1:0] bound_hi,
  input  logic signed [COORD_W-1:0] orig,
  input  logic signed [COORD_W-1:0] dir,
  output logic signed [COORD_W-1:0] slab_lo,
  output logic signed [COORD_W-1:0] slab_hi
);

  logic signed [COORD_W:0]   diff_a;
  logic signed [COORD_W:0]   diff_b;
  logic [COORD_W:0]          mag_a;
  logic [COORD_W:0]          mag_b;
  logic [COORD_W-1:0]        dmag;

  logic [NUM_W-1:0]          num_a_r;
  logic [NUM_W-1:0]          num_b_r;
  logic [COORD_W-1:0]        dmag_r;
  logic                      neg_a_r;
  logic                      neg_b_r;
  logic                      dz_r [0:ST_ORDER-1];
  logic                      in_r [0:ST_ORDER-1];

  logic [COORD_W-1:0]        q_a;
  logic [COORD_W-1:0]        q_b;
  logic                      ovf_a;
  logic                      ovf_b;
  logic                      sn_a;
  logic                      sn_b;
  logic signed [COORD_W-1:0] t_a;
  logic signed [COORD_W-1:0] t_b;
  logic signed [COORD_W-1:0] lo_nxt;
  logic signed [COORD_W-1:0] hi_nxt;
  logic signed [COORD_W-1:0] lo_r;
  logic signed [COORD_W-1:0] hi_r;

  assign diff_a = {bound_lo[COORD_W-1], bound_lo} - {orig[COORD_W-1], orig};
  assign diff_b = {bound_hi[COORD_W-1], bound_hi} - {orig[COORD_W-1], orig};
  assign mag_a  = diff_a[COORD_W] ? -diff_a : diff_a;
  assign mag_b  = diff_b[COORD_W] ? -diff_b : diff_b;
  assign dmag   = dir[COORD_W-1] ? -dir : dir;

  always_ff @(posedge clk) begin
    if (en[ST_PREP]) begin
      num_a_r  <= {mag_a, {FRAC_BITS{1'b0}}};
      num_b_r  <= {mag_b, {FRAC_BITS{1'b0}}};
      dmag_r   <= dmag;
      neg_a_r  <= diff_a[COORD_W] ^ dir[COORD_W-1];
      neg_b_r  <= diff_b[COORD_W] ^ dir[COORD_W-1];
      dz_r[0]  <= (dir == '0);
      in_r[0]  <= (orig >= bound_lo) && (orig <= bound_hi);
    end
  end

  // Zero-direction and origin-inside flags ride alongside the divider.
  for (genvar k = 1; k < ST_ORDER; k++) begin : g_flag
    always_ff @(posedge clk) begin
      if (en[k]) begin
        dz_r[k] <= dz_r[k-1];
        in_r[k] <= in_r[k-1];
      end
    end
  end

  rbsi_div u_div_a (
    .clk     (clk),
    .en      (en[ST_ORDER-1:ST_DIV]),
    .num_mag (num_a_r),
    .den_mag (dmag_r),
    .neg     (neg_a_r),
    .quo     (q_a),
    .ovf     (ovf_a),
    .neg_o   (sn_a)
  );

  rbsi_div u_div_b (
    .clk     (clk),
    .en      (en[ST_ORDER-1:ST_DIV]),
    .num_mag (num_b_r),
    .den_mag (dmag_r),
    .neg     (neg_b_r),
    .quo     (q_b),
    .ovf     (ovf_b),
    .neg_o   (sn_b)
  );

  assign t_a = sat_quo(q_a, ovf_a, sn_a);
  assign t_b = sat_quo(q_b, ovf_b, sn_b);

  always_comb begin
    if (dz_r[ST_ORDER-1]) begin
      lo_nxt = in_r[ST_ORDER-1] ? T_MIN : T_MAX;
      hi_nxt = in_r[ST_ORDER-1] ? T_MAX : T_MIN;
    end else if (t_a < t_b) begin
      lo_nxt = t_a;
      hi_nxt = t_b;
    end else begin
      lo_nxt = t_b;
      hi_nxt = t_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_ORDER]) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  assign slab_lo = lo_r;
  assign slab_hi = hi_r;

endmodule

@@ sv/rbsi_merge.sv @@
// Merging stage: intersects the three slab intervals and picks the reported distance.
module rbsi_merge import rbsi_pkg::*; (
  input  logic                              clk,
  input  logic                              en,
  input  logic [NUM_AXES-1:0][COORD_W-1:0]  slab_lo,
  input  logic [NUM_AXES-1:0][COORD_W-1:0]  slab_hi,
  input  logic [MIND_W-1:0]                 min_dist,
  output res_t                              res
);

  logic signed [COORD_W-1:0] lo;
  logic signed [COORD_W-1:0] hi;
  res_t                      res_nxt;
  res_t                      res_r;

  always_comb begin
    lo = T_MIN;
    hi = T_MAX;
    for (int i = 0; i < NUM_AXES; i++) begin
      if ($signed(slab_lo[i]) > lo) begin
        lo = $signed(slab_lo[i]);
      end
      if ($signed(slab_hi[i]) < hi) begin
        hi = $signed(slab_hi[i]);
      end
    end
    if (hi >= lo) begin
      res_nxt.hit      = 1'b1;
      res_nxt.distance = ($signed({lo[COORD_W-1], lo}) >
                          $signed({{(COORD_W+1-MIND_W){1'b0}}, min_dist})) ? lo : hi;
    end else begin
      res_nxt.hit      = 1'b0;
      res_nxt.distance = T_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ sv/ray_box_slab_intersect_unit.sv @@
// Top level of the ray versus axis-aligned box slab tester with its register port.
//
//  Channel   Direction  Handshake              Payload
//  in_       input      in_valid / in_ready    ray_t: origin_x..z, dir_x..z
//  out_      output     out_valid / out_ready  res_t: hit, distance
//  APB       config     psel/penable/pwrite    box bounds and min_distance
//
// Every ray passes from transfer to result through one preparation stage, one
// divider load stage, 32 divider stages (one quotient bit each), an ordering stage
// and the merging stage that holds the result.
// A new ray is taken every cycle unless every stage is full and the output stalls.
// Reset (synchronous, active low) empties the pipeline and loads the box registers.
// A stall at the output only blocks a stage that is full along with all of
// its successors, so bubbles in the pipeline are squeezed out while a result waits.
module ray_box_slab_intersect_unit import rbsi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ray_t              in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output res_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Box registers; each one is written by a completed APB write transfer.
  logic signed [COORD_W-1:0] box_min_x_r;
  logic signed [COORD_W-1:0] box_min_y_r;
  logic signed [COORD_W-1:0] box_min_z_r;
  logic signed [COORD_W-1:0] box_max_x_r;
  logic signed [COORD_W-1:0] box_max_y_r;
  logic signed [COORD_W-1:0] box_max_z_r;
  logic [MIND_W-1:0]         min_dist_r;
  logic                      wr_en;
  logic [IDX_W-1:0]          reg_idx;

  // Valid bit per stage and the advance enable derived from them.
  logic [NSTG-1:0]           vld_r;
  logic [NSTG-1:0]           vld_nxt;
  logic [NSTG-1:0]           en;

  logic [NUM_AXES-1:0][COORD_W-1:0] slab_lo;
  logic [NUM_AXES-1:0][COORD_W-1:0] slab_hi;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_x_r <= '0;
      box_min_y_r <= '0;
      box_min_z_r <= '0;
      box_max_x_r <= 32'sd65536;
      box_max_y_r <= 32'sd65536;
      box_max_z_r <= 32'sd65536;
      min_dist_r  <= 17'd66;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BOX_MIN_X: box_min_x_r <= pwdata;
        REG_BOX_MIN_Y: box_min_y_r <= pwdata;
        REG_BOX_MIN_Z: box_min_z_r <= pwdata;
        REG_BOX_MAX_X: box_max_x_r <= pwdata;
        REG_BOX_MAX_Y: box_max_y_r <= pwdata;
        REG_BOX_MAX_Z: box_max_z_r <= pwdata;
        REG_MIN_DIST:  min_dist_r  <= pwdata[MIND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BOX_MIN_X: prdata = box_min_x_r;
      REG_BOX_MIN_Y: prdata = box_min_y_r;
      REG_BOX_MIN_Z: prdata = box_min_z_r;
      REG_BOX_MAX_X: prdata = box_max_x_r;
      REG_BOX_MAX_Y: prdata = box_max_y_r;
      REG_BOX_MAX_Z: prdata = box_max_z_r;
      REG_MIN_DIST:  prdata = {{(32-MIND_W){1'b0}}, min_dist_r};
      default:       prdata = '0;
    endcase
  end

  // A stage may load when it or any stage after it is empty, or the output drains.
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = ~(&vld_r[NSTG-1:k]) | out_ready;
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];

  rbsi_slab u_lane_x (
    .clk      (clk),
    .en       (en[ST_ORDER:0]),
    .bound_lo (box_min_x_r),
    .bound_hi (box_max_x_r),
    .orig     (in_data.origin_x),
    .dir      (in_data.dir_x),
    .slab_lo  (slab_lo[0]),
    .slab_hi  (slab_hi[0])
  );

  rbsi_slab u_lane_y (
    .clk      (clk),
    .en       (en[ST_ORDER:0]),
    .bound_lo (box_min_y_r),
    .bound_hi (box_max_y_r),
    .orig     (in_data.origin_y),
    .dir      (in_data.dir_y),
    .slab_lo  (slab_lo[1]),
    .slab_hi  (slab_hi[1])
  );

  rbsi_slab u_lane_z (
    .clk      (clk),
    .en       (en[ST_ORDER:0]),
    .bound_lo (box_min_z_r),
    .bound_hi (box_max_z_r),
    .orig     (in_data.origin_z),
    .dir      (in_data.dir_z),
    .slab_lo  (slab_lo[2]),
    .slab_hi  (slab_hi[2])
  );

  rbsi_merge u_merge (
    .clk      (clk),
    .en       (en[ST_MERGE]),
    .slab_lo  (slab_lo),
    .slab_hi  (slab_hi),
    .min_dist (min_dist_r),
    .res      (out_data)
  );

  // The input is refused only when every stage of the pipeline is occupied.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r))
    else $error("input refused while the pipeline has a bubble");

  // A miss always reports the largest distance.
  a_miss_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.distance == T_MAX))
    else $error("miss reported with a distance other than the maximum");

  // An accepted ray reaches the first stage on the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted ray did not enter the pipeline");

  // A waiting result is never lost while the output is stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result dropped");

endmodule
